/* hdl/assert_macros.svh */
// Assertion macros shared by the tone generator RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hdl/stg_pkg.sv */
// Package for the stereo sine tone generator: sizes, register codes, polynomial
// coefficients and the configuration struct. No dependencies.
`timescale 1ns / 1ps

package stg_pkg;

    localparam int STG_SINE_TABLE_BITS = 10;
    localparam int STG_PHASE_BITS      = 32;
    localparam int STG_SAMPLE_BITS     = 24;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MUTED      = 4'd3;

    localparam logic [31:0]        RESET_PHASE_STEP = 32'd39370534;
    localparam logic [15:0]        RESET_GAIN       = 16'd4096;
    localparam logic signed [15:0] PAN_LIMIT        = 16'sd16384;

    // Shared multiplier operand and product widths.
    localparam int MULT_A_W = 33;
    localparam int MULT_B_W = 31;
    localparam int PROD_W   = MULT_A_W + MULT_B_W;

    // Quarter-wave sine polynomial in unsigned Q1.30; POINT_THREE_Q16 is 0.3 in Q16.
    localparam logic [30:0] Q30_ONE         = 31'd1073741824;
    localparam logic [30:0] COEF_A1         = 31'd1686629713;
    localparam logic [30:0] COEF_A3         = 31'd693598669;
    localparam logic [30:0] COEF_A5         = 31'd85569278;
    localparam logic [30:0] COEF_A7         = 31'd5026991;
    localparam logic [30:0] POINT_THREE_Q16 = 31'd19661;

    typedef struct packed {
        logic [31:0]        phase_step;
        logic [15:0]        gain;
        logic signed [15:0] pan;
        logic               muted;
    } cfg_t;

endpackage

/* hdl/stg_if.sv */
// Handshake channels of the tone generator: frame requests in, stereo words out.
// Depends on stg_pkg for the default sample width.
`timescale 1ns / 1ps

interface stg_tick_if;
    logic valid;
    logic ready;
    logic frame_tick;
    logic block_end;

    modport source (output valid, output frame_tick, output block_end, input ready);
    modport sink (input valid, input frame_tick, input block_end, output ready);
endinterface

interface stg_frame_if
    import stg_pkg::*;
#(
    parameter int SAMPLE_BITS = STG_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          block_end_out;

    modport source (output valid, output left_sample, output right_sample,
                    output block_end_out, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input block_end_out, output ready);
endinterface

/* hdl/stg_mult.sv */
// Shared unsigned multiplier with a registered product.
// Depends on stg_pkg for operand widths.
`timescale 1ns / 1ps

module stg_mult
    import stg_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [MULT_A_W-1:0] a,
    input  logic [MULT_B_W-1:0] b,
    output logic [PROD_W-1:0]   prod_reg
);

    logic [PROD_W-1:0] prod_next;

    assign prod_next = a * b;

    // The product holds while the sequencer is not issuing an operation.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

endmodule

/* hdl/stg_cfg.sv */
// Configuration registers of the tone generator, with pan saturation on write.
// Depends on stg_pkg for register codes, reset values and the cfg_t struct.
`timescale 1ns / 1ps

module stg_cfg
    import stg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  index,
    input  logic [CFG_DATA_W-1:0] wdata,
    output cfg_t                  cfg,
    output logic                  coef_wr
);

    logic [31:0]        phase_step_reg;
    logic [15:0]        gain_reg;
    logic signed [15:0] pan_reg;
    logic               muted_reg;
    logic signed [15:0] pan_in;
    logic signed [15:0] pan_sat;

    assign pan_in = wdata[15:0];

    always_comb
    begin
        if (pan_in > PAN_LIMIT)
        begin
            pan_sat = PAN_LIMIT;
        end
        else if (pan_in < -PAN_LIMIT)
        begin
            pan_sat = -PAN_LIMIT;
        end
        else
        begin
            pan_sat = pan_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= RESET_PHASE_STEP;
            gain_reg       <= RESET_GAIN;
            pan_reg        <= '0;
            muted_reg      <= 1'b0;
        end
        else if (we)
        begin
            case (index)
                REG_PHASE_STEP: phase_step_reg <= wdata[31:0];
                REG_GAIN:       gain_reg       <= wdata[15:0];
                REG_PAN:        pan_reg        <= pan_sat;
                REG_MUTED:      muted_reg      <= wdata[0];
                default:        ;
            endcase
        end
    end

    // Gain and pan feed the cached coefficients, so a write to either marks them stale.
    assign coef_wr = we && ((index == REG_GAIN) || (index == REG_PAN));

    assign cfg.phase_step = phase_step_reg;
    assign cfg.gain       = gain_reg;
    assign cfg.pan        = pan_reg;
    assign cfg.muted      = muted_reg;

endmodule

/* hdl/sine_tone_generator_stereo_pan.sv */
// Top level of the stereo sine tone generator: sequencer, phase accumulator and output word.
// Depends on stg_pkg, stg_if, stg_cfg, stg_mult and assert_macros.svh.
`timescale 1ns / 1ps

// Each accepted tick yields one stereo word. A single 33x31 multiplier does all the
// multiplications under a sequencer: the quarter-sine polynomial (ST_QS_SQ to ST_QS_CL),
// then scaling and the two pan products (ST_FM_MAG to ST_FM_R); a muted frame goes straight
// to ST_FM_R. No new tick is taken until the frame is done and the sequencer is idle. The
// gain factor and the pan gains are cached: after reset, and after every write to gain or pan,
// the block refreshes them (two polynomial runs on the same multiplier) with ready low. A
// finished word waits in the output register while the next tick is taken. Samples are
// signed Q1.(SAMPLE_BITS-1), rounded and saturated.
module sine_tone_generator_stereo_pan
    import stg_pkg::*;
#(
    parameter int SINE_TABLE_BITS = STG_SINE_TABLE_BITS,
    parameter int PHASE_BITS      = STG_PHASE_BITS,
    parameter int SAMPLE_BITS     = STG_SAMPLE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    stg_tick_if.sink              tick,
    stg_frame_if.source           frame,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "assert_macros.svh"

    localparam int ACC_W = (PHASE_BITS > 32) ? PHASE_BITS : 32;
    localparam int X_W   = SINE_TABLE_BITS - 2;
    localparam int U_SH  = 30 - X_W;
    localparam int SH    = 61 - SAMPLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RC_GK, ST_RC_PAN,
        ST_QS_SQ, ST_QS_M7, ST_QS_P5, ST_QS_M5, ST_QS_P3, ST_QS_M3, ST_QS_P1,
        ST_QS_MU, ST_QS_CL,
        ST_FM_MAG, ST_FM_L, ST_FM_LR, ST_FM_R
    } state_t;

    typedef enum logic [1:0] {
        RET_SINE, RET_GR, RET_GL
    } ret_t;

    cfg_t cfg;
    logic coef_wr;

    state_t state_reg;
    ret_t   ret_reg;
    logic   dirty_reg;
    logic   mute_reg;
    logic   neg_reg;
    logic   bend_reg;

    logic [PHASE_BITS-1:0] phase_reg;
    logic [ACC_W-1:0]      phase_sum;
    logic [PHASE_BITS-1:0] phase_next;

    logic [30:0] u_reg;
    logic [30:0] u2_reg;
    logic [30:0] p_reg;
    logic [30:0] s_reg;
    logic [30:0] gk_reg;
    logic [30:0] gr_reg;
    logic [30:0] gl_reg;
    logic [32:0] mag_reg;

    logic signed [SAMPLE_BITS-1:0] left_q_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          out_bend_reg;
    logic                          out_valid_reg;

    logic                mult_en;
    logic [MULT_A_W-1:0] mult_a;
    logic [MULT_B_W-1:0] mult_b;
    logic [PROD_W-1:0]   prod;

    logic [SINE_TABLE_BITS-1:0] k;
    logic [1:0]                 quad;
    logic [30:0]                u_raw;
    logic [30:0]                u_tick;
    logic signed [16:0]         pan_ext;
    logic signed [16:0]         pan_r_sum;
    logic signed [16:0]         pan_l_sum;
    logic [30:0]                u_pan_r;
    logic [30:0]                u_pan_l;
    logic [30:0]                coef_sel;
    logic [31:0]                p_diff;
    logic [31:0]                cl_t;
    logic [30:0]                cl_s;
    logic signed [SAMPLE_BITS-1:0] sample_val;

    logic tick_fire;
    logic slot_free;

    stg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (cfg_we),
        .index   (cfg_index),
        .wdata   (cfg_wdata),
        .cfg     (cfg),
        .coef_wr (coef_wr)
    );

    stg_mult u_mult (
        .clk      (clk),
        .en       (mult_en),
        .a        (mult_a),
        .b        (mult_b),
        .prod_reg (prod)
    );

    // Round half away from zero on the magnitude, saturate, then apply the sign.
    function automatic logic signed [SAMPLE_BITS-1:0] make_sample(
        input logic [PROD_W-1:0] pr,
        input logic              neg
    );
        logic [PROD_W:0] sum;
        logic [PROD_W:0] r;
        logic [PROD_W:0] lim;
        logic [PROD_W:0] v;
        sum = {1'b0, pr} + ((PROD_W + 1)'(1) << (SH - 1));
        r   = sum >> SH;
        lim = (PROD_W + 1)'(1) << (SAMPLE_BITS - 1);
        if (neg)
        begin
            v = (r > lim) ? lim : r;
            v = (PROD_W + 1)'(0) - v;
        end
        else
        begin
            v = (r > (lim - 1'b1)) ? (lim - 1'b1) : r;
        end
        make_sample = v[SAMPLE_BITS-1:0];
    endfunction

    assign phase_sum  = ACC_W'(phase_reg) + ACC_W'(cfg.phase_step);
    assign phase_next = phase_sum[PHASE_BITS-1:0];

    // Table index from the top phase bits; odd quadrants run the quarter wave backwards.
    assign k      = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign quad   = k[SINE_TABLE_BITS-1 -: 2];
    assign u_raw  = 31'(k[X_W-1:0]) << U_SH;
    assign u_tick = quad[0] ? (Q30_ONE - u_raw) : u_raw;

    assign pan_ext   = 17'(cfg.pan);
    assign pan_r_sum = pan_ext + 17'sd16384;
    assign pan_l_sum = 17'sd16384 - pan_ext;
    assign u_pan_r   = {pan_r_sum[15:0], 15'd0};
    assign u_pan_l   = {pan_l_sum[15:0], 15'd0};

    always_comb
    begin
        case (state_reg)
            ST_QS_P5: coef_sel = COEF_A5;
            ST_QS_P3: coef_sel = COEF_A3;
            default:  coef_sel = COEF_A1;
        endcase
    end

    assign p_diff     = {1'b0, coef_sel} - prod[61:30];
    assign cl_t       = prod[61:30];
    assign cl_s       = (cl_t > {1'b0, Q30_ONE}) ? Q30_ONE : cl_t[30:0];
    assign sample_val = make_sample(prod, neg_reg);

    assign tick_fire = tick.valid && tick.ready;
    assign slot_free = !out_valid_reg || frame.ready;

    always_comb
    begin
        mult_en = 1'b1;
        mult_a  = '0;
        mult_b  = '0;
        case (state_reg)
            ST_RC_GK:
            begin
                mult_a = MULT_A_W'(cfg.gain);
                mult_b = POINT_THREE_Q16;
            end
            ST_QS_SQ:
            begin
                mult_a = MULT_A_W'(u_reg);
                mult_b = u_reg;
            end
            ST_QS_M7:
            begin
                mult_a = MULT_A_W'(prod[60:30]);
                mult_b = COEF_A7;
            end
            ST_QS_M5, ST_QS_M3:
            begin
                mult_a = MULT_A_W'(u2_reg);
                mult_b = p_reg;
            end
            ST_QS_MU:
            begin
                mult_a = MULT_A_W'(u_reg);
                mult_b = p_reg;
            end
            ST_FM_MAG:
            begin
                mult_a = MULT_A_W'(s_reg);
                mult_b = gk_reg;
            end
            ST_FM_L:
            begin
                mult_a = prod[60:28];
                mult_b = gl_reg;
            end
            ST_FM_LR:
            begin
                mult_a = mag_reg;
                mult_b = gr_reg;
            end
            default:
            begin
                mult_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_SINE;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            mute_reg      <= 1'b0;
            neg_reg       <= 1'b0;
            bend_reg      <= 1'b0;
            u_reg         <= '0;
            u2_reg        <= '0;
            p_reg         <= '0;
            s_reg         <= '0;
            gk_reg        <= '0;
            gr_reg        <= '0;
            gl_reg        <= '0;
            mag_reg       <= '0;
            left_q_reg    <= '0;
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_bend_reg  <= 1'b0;
        end
        else
        begin
            if (coef_wr)
            begin
                dirty_reg <= 1'b1;
            end
            else if ((state_reg == ST_IDLE) && dirty_reg)
            begin
                dirty_reg <= 1'b0;
            end

            if ((state_reg == ST_FM_R) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (dirty_reg)
                    begin
                        state_reg <= ST_RC_GK;
                    end
                    else if (tick.valid)
                    begin
                        bend_reg <= tick.block_end;
                        mute_reg <= cfg.muted;
                        neg_reg  <= quad[1];
                        u_reg    <= u_tick;
                        ret_reg  <= RET_SINE;
                        if (cfg.muted)
                        begin
                            state_reg <= ST_FM_R;
                        end
                        else
                        begin
                            phase_reg <= phase_next;
                            state_reg <= ST_QS_SQ;
                        end
                    end
                end
                ST_RC_GK:
                begin
                    state_reg <= ST_RC_PAN;
                end
                ST_RC_PAN:
                begin
                    gk_reg    <= prod[30:0];
                    u_reg     <= u_pan_r;
                    ret_reg   <= RET_GR;
                    state_reg <= ST_QS_SQ;
                end
                ST_QS_SQ: state_reg <= ST_QS_M7;
                ST_QS_M7:
                begin
                    u2_reg    <= prod[60:30];
                    state_reg <= ST_QS_P5;
                end
                ST_QS_P5:
                begin
                    p_reg     <= p_diff[30:0];
                    state_reg <= ST_QS_M5;
                end
                ST_QS_M5: state_reg <= ST_QS_P3;
                ST_QS_P3:
                begin
                    p_reg     <= p_diff[30:0];
                    state_reg <= ST_QS_M3;
                end
                ST_QS_M3: state_reg <= ST_QS_P1;
                ST_QS_P1:
                begin
                    p_reg     <= p_diff[30:0];
                    state_reg <= ST_QS_MU;
                end
                ST_QS_MU: state_reg <= ST_QS_CL;
                ST_QS_CL:
                begin
                    case (ret_reg)
                        RET_SINE:
                        begin
                            s_reg     <= cl_s;
                            state_reg <= ST_FM_MAG;
                        end
                        RET_GR:
                        begin
                            gr_reg    <= cl_s;
                            u_reg     <= u_pan_l;
                            ret_reg   <= RET_GL;
                            state_reg <= ST_QS_SQ;
                        end
                        default:
                        begin
                            gl_reg    <= cl_s;
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_FM_MAG: state_reg <= ST_FM_L;
                ST_FM_L:
                begin
                    mag_reg   <= prod[60:28];
                    state_reg <= ST_FM_LR;
                end
                ST_FM_LR:
                begin
                    left_q_reg <= sample_val;
                    state_reg  <= ST_FM_R;
                end
                ST_FM_R:
                begin
                    // The right product stays in the multiplier until the output word frees up.
                    if (slot_free)
                    begin
                        out_left_reg  <= mute_reg ? '0 : left_q_reg;
                        out_right_reg <= mute_reg ? '0 : sample_val;
                        out_bend_reg  <= bend_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign tick.ready          = (state_reg == ST_IDLE) && !dirty_reg;
    assign frame.valid         = out_valid_reg;
    assign frame.left_sample   = out_left_reg;
    assign frame.right_sample  = out_right_reg;
    assign frame.block_end_out = out_bend_reg;

    `ASSERT_CLK(a_phase_advance, clk, rst_n, (tick_fire && !cfg.muted) |=> (phase_reg == $past(phase_next)), "phase did not advance by the step on an unmuted frame")
    `ASSERT_CLK(a_phase_hold, clk, rst_n, (tick_fire && cfg.muted) |=> $stable(phase_reg), "phase moved on a muted frame")
    `ASSERT_CLK(a_busy_after_tick, clk, rst_n, tick_fire |=> !tick.ready, "ready stayed high right after a tick was taken")
    `ASSERT_NEVER(a_pan_range, clk, rst_n, (cfg.pan > PAN_LIMIT) || (cfg.pan < -PAN_LIMIT), "pan register outside its saturated range")

endmodule

/* dv/sine_tone_generator_stereo_pan_tb.sv */
// Testbench for the stereo sine tone generator: frame ticks in, panned stereo words out.
// Depends on stg_pkg, the stg_if channel interfaces and the sine_tone_generator_stereo_pan RTL.
`timescale 1ns / 1ps

module sine_tone_generator_stereo_pan_tb;
    import stg_pkg::*;

    localparam int SW          = STG_SAMPLE_BITS;
    localparam int TABLE_BITS  = STG_SINE_TABLE_BITS;
    localparam int SETTLE      = 30;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 95;
    localparam int NUM_PHASES  = 9;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MUTED + 1'b1;

    typedef struct {
        logic [SW-1:0] left;
        logic [SW-1:0] right;
        logic          block_end;
    } stereo_word_t;

    class tone_checker;
        logic [31:0]    phase;
        logic [31:0]    step;
        logic [15:0]    gain;
        int             pan;
        bit             muted;
        stereo_word_t   expected_words[$];
        int             mismatches;

        function new();
            phase      = '0;
            step       = RESET_PHASE_STEP;
            gain       = RESET_GAIN;
            pan        = 0;
            muted      = 1'b0;
            mismatches = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int p;
            case (idx)
                REG_PHASE_STEP: step = data;
                REG_GAIN:       gain = data[15:0];
                REG_PAN:
                begin
                    p = int'(signed'(data[15:0]));
                    if (p > int'(PAN_LIMIT))
                        p = int'(PAN_LIMIT);
                    if (p < -int'(PAN_LIMIT))
                        p = -int'(PAN_LIMIT);
                    pan = p;
                end
                REG_MUTED:      muted = data[0];
                default:        ;
            endcase
        endfunction

        // sin(pi/2 * u) in Q2.30, u in Q0.30, odd polynomial in Horner form.
        function bit [63:0] quarter_wave(bit [63:0] u);
            bit [63:0] one, u2, acc, s;
            one = 64'(Q30_ONE);
            if (u > one)
                u = one;
            u2  = (u * u) >> 30;
            acc = 64'(COEF_A7);
            acc = 64'(COEF_A5) - ((u2 * acc) >> 30);
            acc = 64'(COEF_A3) - ((u2 * acc) >> 30);
            acc = 64'(COEF_A1) - ((u2 * acc) >> 30);
            s   = (u * acc) >> 30;
            return (s > one) ? one : s;
        endfunction

        function bit [SW-1:0] round_sample(bit [63:0] mag, bit neg, bit [63:0] pan_gain);
            bit [63:0] r, lim;
            lim = 64'd1 << (SW - 1);
            r   = (mag * pan_gain + (64'd1 << (60 - SW))) >> (61 - SW);
            if (neg)
            begin
                if (r > lim)
                    r = lim;
                r = -r;
            end
            else if (r > lim - 1)
            begin
                r = lim - 1;
            end
            return r[SW-1:0];
        endfunction

        function void note_tick(logic block_end);
            stereo_word_t        w;
            bit [TABLE_BITS-1:0] k;
            bit [1:0]            quad;
            bit [63:0]           u, s, mag, gl, gr;
            w.left      = '0;
            w.right     = '0;
            w.block_end = block_end;
            if (!muted)
            begin
                k    = phase[31 -: TABLE_BITS];
                quad = k[TABLE_BITS-1 -: 2];
                u    = 64'(k[TABLE_BITS-3:0]) << (30 - (TABLE_BITS - 2));
                if (quad[0])
                    u = 64'(Q30_ONE) - u;
                s       = quarter_wave(u);
                mag     = (s * 64'(gain) * 64'(POINT_THREE_Q16)) >> 28;
                gr      = quarter_wave(64'(pan + int'(PAN_LIMIT)) << 15);
                gl      = quarter_wave(64'(int'(PAN_LIMIT) - pan) << 15);
                w.left  = round_sample(mag, quad[1], gl);
                w.right = round_sample(mag, quad[1], gr);
                phase   = phase + step;
            end
            expected_words.push_back(w);
        endfunction

        task check_word(logic [SW-1:0] left, logic [SW-1:0] right, logic block_end);
            stereo_word_t want;
            if (expected_words.size() == 0)
            begin
                report("stereo word with no tick outstanding");
                return;
            end
            want = expected_words.pop_front();
            if (left !== want.left)
                report($sformatf("left sample %0d, expected %0d",
                                 signed'(left), signed'(want.left)));
            if (right !== want.right)
                report($sformatf("right sample %0d, expected %0d",
                                 signed'(right), signed'(want.right)));
            if (block_end !== want.block_end)
                report($sformatf("block_end_out %b, expected %b", block_end, want.block_end));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    stg_tick_if  tick_ch ();
    stg_frame_if frame_ch ();

    tone_checker tones;
    bit          calm;
    bit          backpressure_req;

    sine_tone_generator_stereo_pan u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_ch),
        .frame     (frame_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Output side: checks every accepted word and drives ready for the next edge.
    initial
    begin
        int hold_count;
        hold_count     = 0;
        frame_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && frame_ch.valid && frame_ch.ready)
                tones.check_word(frame_ch.left_sample, frame_ch.right_sample,
                                 frame_ch.block_end_out);
            if (hold_count != 0)
            begin
                hold_count--;
                frame_ch.ready <= 1'b0;
            end
            else if (backpressure_req)
            begin
                backpressure_req = 1'b0;
                hold_count       = HOLD_CYCLES;
                frame_ch.ready <= 1'b0;
            end
            else
            begin
                frame_ch.ready <= calm || ($urandom_range(99) >= 13);
            end
        end
    end

    task automatic send_tick(input logic block_end, input logic frame_tick);
        if (!calm && $urandom_range(99) < 13)
        begin
            tick_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.block_end  <= block_end;
        tick_ch.frame_tick <= frame_tick;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        tones.note_tick(block_end);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++)
            send_tick(1'($urandom_range(1)), ($urandom_range(15) != 0));
        tick_ch.valid <= 1'b0;
    endtask

    // Waits until every expected word has come out, then lets the pipeline settle.
    task automatic drain();
        while (tones.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        tones.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic random_settings();
        logic [31:0] value;
        if ($urandom_range(3) != 0)
        begin
            case ($urandom_range(5))
                0:       value = '0;
                1:       value = '1;
                default: value = $urandom;
            endcase
            write_reg(REG_PHASE_STEP, value);
        end
        if ($urandom_range(3) != 0)
        begin
            case ($urandom_range(5))
                0:       value = '0;
                1:       value = 32'h0000_FFFF;
                2:       value = $urandom;
                default: value = $urandom_range(8192);
            endcase
            write_reg(REG_GAIN, value);
        end
        if ($urandom_range(3) != 0)
        begin
            if ($urandom_range(3) == 0)
                value = $urandom;
            else
                value = 32'($urandom_range(2 * int'(PAN_LIMIT)) - int'(PAN_LIMIT));
            write_reg(REG_PAN, value);
        end
        if ($urandom_range(5) == 0)
            write_reg(CFG_IDX_W'($urandom_range(15, REG_FIRST_UNUSED)), $urandom);
        write_reg(REG_MUTED, CFG_DATA_W'($urandom_range(7) == 0));
    endtask

    initial
    begin
        tones              = new();
        calm               = 1'b0;
        backpressure_req   = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.frame_tick = 1'b1;
        tick_ch.block_end  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings, both block_end values and an ignored frame_tick of zero.
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        tick_ch.valid <= 1'b0;
        drain();

        // Quarter-cycle steps visit each quadrant at the same offset; full gain saturates both signs.
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_GAIN, 32'h0000_FFFF);
        send_ticks(4);
        drain();

        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_GAIN, CFG_DATA_W'(RESET_GAIN));
        write_reg(REG_PAN, 32'(PAN_LIMIT));
        send_ticks(3);
        drain();

        // Pan writes beyond either end are clamped; only the low half of the data counts.
        write_reg(REG_PHASE_STEP, 32'h0000_0000);
        write_reg(REG_PAN, 32'h0000_7FFF);
        send_ticks(2);
        drain();
        write_reg(REG_PHASE_STEP, 32'h8000_0000);
        write_reg(REG_PAN, 32'hABCD_8000);
        send_ticks(2);
        drain();

        write_reg(REG_GAIN, 32'h0000_0000);
        send_ticks(2);
        drain();

        // Muted frames are silent and hold the phase; a write to an unused index is dropped.
        write_reg(REG_GAIN, 32'h0000_2000);
        write_reg(REG_PHASE_STEP, 32'h1234_5679);
        write_reg(REG_MUTED, 32'd1);
        send_ticks(3);
        drain();
        write_reg(REG_FIRST_UNUSED, 32'hFFFF_FFFF);
        write_reg(REG_MUTED, 32'd0);
        send_ticks(2);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            random_settings();
            calm = (p == 2);
            if (p == 5)
                backpressure_req = 1'b1;
            send_ticks(PHASE_ITEMS);
            drain();
        end
        calm = 1'b0;

        if (tones.expected_words.size() != 0)
            tones.report("stereo words still expected at the end");
        if (tones.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/stg_pkg.sv
hdl/stg_if.sv
hdl/stg_mult.sv
hdl/stg_cfg.sv
hdl/sine_tone_generator_stereo_pan.sv
dv/sine_tone_generator_stereo_pan_tb.sv
